// ===== rtl/core/sdi_pkg.sv =====
// ---------------------------------------------------------------------------
// sdi_pkg: shared types and constants of the SD card init sequencer
// Transaction layouts, phase encoding, command codes and result builders.
// ---------------------------------------------------------------------------
package sdi_pkg;

  localparam int RES_SLOTS = 3;

  localparam logic [31:0] ARG_CHECK     = 32'h0000_01AA;
  localparam logic [31:0] OCR_HCS       = 32'h4000_0000;
  localparam logic [31:0] OCR_XPC       = 32'h1000_0000;
  localparam logic [31:0] OCR_V33       = 32'h0010_0000;
  localparam int          OCR_READY_BIT = 31;
  localparam logic [31:0] SWITCH_HS_ARG = 32'h80FF_FF01;
  localparam logic [31:0] BLOCK_LEN     = 32'd512;
  localparam logic [31:0] BUS_WIDTH_4   = 32'd2;
  localparam logic [6:0]  SWITCH_BYTES  = 7'd64;
  localparam logic [3:0]  GROUP1_HS     = 4'd1;
  localparam logic [3:0]  PROBE_MAX     = 4'd15;
  localparam logic [9:0]  POLL_MAX      = 10'd1023;

  // Configuration register indexes
  localparam logic CFG_PROBE_LIMIT = 1'b0;
  localparam logic CFG_POLL_LIMIT  = 1'b1;

  localparam logic [3:0] PROBE_LIMIT_RST = 4'd10;
  localparam logic [9:0] POLL_LIMIT_RST  = 10'd200;

  // SD command indexes
  localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
  localparam logic [5:0] CMD_ALL_CID    = 6'd2;
  localparam logic [5:0] CMD_SEND_RCA   = 6'd3;
  localparam logic [5:0] CMD_SWITCH     = 6'd6;
  localparam logic [5:0] ACMD_BUS_WIDTH = 6'd6;
  localparam logic [5:0] CMD_SELECT     = 6'd7;
  localparam logic [5:0] CMD_IF_COND    = 6'd8;
  localparam logic [5:0] CMD_BLOCKLEN   = 6'd16;
  localparam logic [5:0] ACMD_OP_COND   = 6'd41;
  localparam logic [5:0] CMD_APP        = 6'd55;

  typedef enum logic [1:0] {
    OP_START     = 2'd0,
    OP_CMD_DONE  = 2'd1,
    OP_READ_DONE = 2'd2,
    OP_NONE      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACT_CMD    = 2'd0,
    ACT_TIMING = 2'd1,
    ACT_TEST   = 2'd2,
    ACT_FINISH = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    TM_IDENT = 2'd0,
    TM_STD   = 2'd1,
    TM_HS    = 2'd2
  } timing_t;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_PROBE     = 4'd1,
    PH_POLL_APP  = 4'd2,
    PH_POLL_OP   = 4'd3,
    PH_CID       = 4'd4,
    PH_RCA       = 4'd5,
    PH_SELECT    = 4'd6,
    PH_BUS_APP   = 4'd7,
    PH_BUS_WIDTH = 4'd8,
    PH_SWITCH    = 4'd9,
    PH_BLOCKLEN  = 4'd10,
    PH_TEST      = 4'd11,
    PH_DONE      = 4'd12
  } phase_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic        status_ok;
    logic [31:0] response_word;
    logic [3:0]  group1_function;
    logic        data_ok;
  } item_t;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  probe_count;
    logic [9:0]  poll_count;
    logic        version_two;
    logic [31:0] relative_address;
    logic        high_speed_on;
  } state_t;

  typedef struct packed {
    action_t     action;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_argument;
    logic        skip_crc_check;
    logic        stop_clock_after;
    logic        expect_response;
    logic [6:0]  read_bytes;
    logic [1:0]  timing_mode;
    logic        success;
    logic        high_capacity;
    logic        last;
  } result_t;

  function automatic result_t mk_cmd(logic [5:0] idx, logic [31:0] arg, logic skip,
                                     logic stop, logic [6:0] nbytes);
    result_t r;
    r                  = '0;
    r.action           = ACT_CMD;
    r.cmd_index        = idx;
    r.cmd_argument     = arg;
    r.skip_crc_check   = skip;
    r.stop_clock_after = stop;
    r.expect_response  = (idx != CMD_GO_IDLE);
    r.read_bytes       = nbytes;
    return r;
  endfunction

  function automatic result_t mk_timing(timing_t mode);
    result_t r;
    r             = '0;
    r.action      = ACT_TIMING;
    r.timing_mode = mode;
    return r;
  endfunction

  function automatic result_t mk_finish(logic ok, logic v2);
    result_t r;
    r               = '0;
    r.action        = ACT_FINISH;
    r.success       = ok;
    r.high_capacity = ok & v2;
    return r;
  endfunction

  function automatic result_t mk_test();
    result_t r;
    r        = '0;
    r.action = ACT_TEST;
    return r;
  endfunction

endpackage

// ===== rtl/core/sdi_step.sv =====
// ---------------------------------------------------------------------------
// sdi_step: sequencer decision logic
// Maps the current state and one event to the next state and up to three
// results.
// ---------------------------------------------------------------------------
module sdi_step (
  input  sdi_pkg::state_t  st,
  input  sdi_pkg::item_t   item,
  input  logic [3:0]       probe_limit,
  input  logic [9:0]       poll_limit,
  output sdi_pkg::state_t  st_nxt,
  output sdi_pkg::result_t res [sdi_pkg::RES_SLOTS],
  output logic [1:0]       res_cnt
);
  import sdi_pkg::*;

  logic [3:0]  probe_inc;
  logic [3:0]  probe_lim;
  logic        probe_more;
  logic        probe_pass;
  logic [9:0]  poll_inc;
  logic        poll_expired;
  logic        hs_ok;
  logic [31:0] op_cond_arg;
  logic        ok;
  op_t         op;

  assign op           = op_t'(item.operation);
  assign ok           = item.status_ok;
  assign probe_pass   = ok && (item.response_word == ARG_CHECK);
  assign probe_inc    = (st.probe_count < PROBE_MAX) ? st.probe_count + 4'd1 : st.probe_count;
  assign probe_lim    = (probe_limit == 4'd0) ? 4'd1 : probe_limit;
  assign probe_more   = probe_inc < probe_lim;
  assign poll_inc     = (st.poll_count < POLL_MAX) ? st.poll_count + 10'd1 : st.poll_count;
  assign poll_expired = poll_inc >= poll_limit;
  assign hs_ok        = ok && item.data_ok && (item.group1_function == GROUP1_HS);
  assign op_cond_arg  = (st.version_two ? (OCR_HCS | OCR_XPC) : 32'd0) | OCR_V33;

  // Next state
  always_comb begin
    st_nxt = st;
    case (op)
      OP_START: begin
        st_nxt       = '0;
        st_nxt.phase = PH_PROBE;
      end
      OP_CMD_DONE: begin
        case (st.phase)
          PH_PROBE: begin
            if (probe_pass) begin
              st_nxt.version_two = 1'b1;
              st_nxt.phase       = PH_POLL_APP;
            end else begin
              st_nxt.probe_count = probe_inc;
              if (!probe_more) st_nxt.phase = PH_POLL_APP;
            end
          end
          PH_POLL_APP: st_nxt.phase = ok ? PH_POLL_OP : PH_DONE;
          PH_POLL_OP: begin
            if (!ok) begin
              st_nxt.phase = PH_DONE;
            end else begin
              st_nxt.poll_count = poll_inc;
              if (poll_expired)                            st_nxt.phase = PH_DONE;
              else if (item.response_word[OCR_READY_BIT])  st_nxt.phase = PH_CID;
              else                                         st_nxt.phase = PH_POLL_APP;
            end
          end
          PH_CID:       st_nxt.phase = ok ? PH_RCA : PH_DONE;
          PH_RCA: begin
            st_nxt.phase = ok ? PH_SELECT : PH_DONE;
            if (ok) st_nxt.relative_address = item.response_word;
          end
          PH_SELECT:    st_nxt.phase = ok ? PH_BUS_APP : PH_DONE;
          PH_BUS_APP:   st_nxt.phase = ok ? PH_BUS_WIDTH : PH_DONE;
          PH_BUS_WIDTH: st_nxt.phase = ok ? PH_SWITCH : PH_DONE;
          PH_SWITCH: begin
            st_nxt.high_speed_on = hs_ok;
            st_nxt.phase         = PH_BLOCKLEN;
          end
          PH_BLOCKLEN:  st_nxt.phase = st.high_speed_on ? PH_TEST : PH_DONE;
          default: ;
        endcase
      end
      OP_READ_DONE: begin
        if (st.phase == PH_TEST) begin
          if (ok) begin
            st_nxt.phase = PH_DONE;
          end else begin
            st_nxt.high_speed_on = 1'b0;
            st_nxt.phase         = PH_BLOCKLEN;
          end
        end
      end
      default: ;
    endcase
  end

  // Results
  always_comb begin
    for (int i = 0; i < RES_SLOTS; i++) res[i] = '0;
    res_cnt = 2'd0;
    case (op)
      OP_START: begin
        res[0]  = mk_timing(TM_IDENT);
        res[1]  = mk_cmd(CMD_GO_IDLE, 32'd0, 1'b0, 1'b0, 7'd0);
        res[2]  = mk_cmd(CMD_IF_COND, ARG_CHECK, 1'b0, 1'b0, 7'd0);
        res_cnt = 2'd3;
      end
      OP_CMD_DONE: begin
        case (st.phase)
          PH_PROBE: begin
            if (probe_pass) begin
              res[0]  = mk_cmd(CMD_APP, 32'd0, 1'b0, 1'b0, 7'd0);
              res_cnt = 2'd1;
            end else begin
              res[0]  = mk_cmd(CMD_GO_IDLE, 32'd0, 1'b0, 1'b0, 7'd0);
              res[1]  = probe_more ? mk_cmd(CMD_IF_COND, ARG_CHECK, 1'b0, 1'b0, 7'd0)
                                   : mk_cmd(CMD_APP, 32'd0, 1'b0, 1'b0, 7'd0);
              res_cnt = 2'd2;
            end
          end
          PH_POLL_APP: begin
            res[0]  = ok ? mk_cmd(ACMD_OP_COND, op_cond_arg, 1'b1, 1'b0, 7'd0)
                         : mk_finish(1'b0, 1'b0);
            res_cnt = 2'd1;
          end
          PH_POLL_OP: begin
            if (!ok || poll_expired)
              res[0] = mk_finish(1'b0, 1'b0);
            else if (item.response_word[OCR_READY_BIT])
              res[0] = mk_cmd(CMD_ALL_CID, 32'd0, 1'b1, 1'b0, 7'd0);
            else
              res[0] = mk_cmd(CMD_APP, 32'd0, 1'b0, 1'b0, 7'd0);
            res_cnt = 2'd1;
          end
          PH_CID: begin
            res[0]  = ok ? mk_cmd(CMD_SEND_RCA, 32'd0, 1'b0, 1'b0, 7'd0)
                         : mk_finish(1'b0, 1'b0);
            res_cnt = 2'd1;
          end
          PH_RCA: begin
            res[0]  = ok ? mk_cmd(CMD_SELECT, item.response_word, 1'b0, 1'b0, 7'd0)
                         : mk_finish(1'b0, 1'b0);
            res_cnt = 2'd1;
          end
          PH_SELECT: begin
            res[0]  = ok ? mk_cmd(CMD_APP, st.relative_address, 1'b0, 1'b0, 7'd0)
                         : mk_finish(1'b0, 1'b0);
            res_cnt = 2'd1;
          end
          PH_BUS_APP: begin
            res[0]  = ok ? mk_cmd(ACMD_BUS_WIDTH, BUS_WIDTH_4, 1'b0, 1'b0, 7'd0)
                         : mk_finish(1'b0, 1'b0);
            res_cnt = 2'd1;
          end
          PH_BUS_WIDTH: begin
            res[0]  = ok ? mk_cmd(CMD_SWITCH, SWITCH_HS_ARG, 1'b0, 1'b1, SWITCH_BYTES)
                         : mk_finish(1'b0, 1'b0);
            res_cnt = 2'd1;
          end
          PH_SWITCH: begin
            res[0]  = mk_timing(hs_ok ? TM_HS : TM_STD);
            res[1]  = mk_cmd(CMD_BLOCKLEN, BLOCK_LEN, 1'b0, 1'b0, 7'd0);
            res_cnt = 2'd2;
          end
          PH_BLOCKLEN: begin
            res[0]  = st.high_speed_on ? mk_test() : mk_finish(1'b1, st.version_two);
            res_cnt = 2'd1;
          end
          default: ;
        endcase
      end
      OP_READ_DONE: begin
        if (st.phase == PH_TEST) begin
          if (ok) begin
            res[0]  = mk_finish(1'b1, st.version_two);
            res_cnt = 2'd1;
          end else begin
            res[0]  = mk_timing(TM_STD);
            res[1]  = mk_cmd(CMD_BLOCKLEN, BLOCK_LEN, 1'b0, 1'b0, 7'd0);
            res_cnt = 2'd2;
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < RES_SLOTS; i++) res[i].last = (res_cnt == 2'(i + 1));
  end

endmodule

// ===== rtl/core/sdi_result_bank.sv =====
// ---------------------------------------------------------------------------
// sdi_result_bank: result register bank
// Holds the results of one event and presents them one transaction at a time.
// ---------------------------------------------------------------------------
module sdi_result_bank (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  sdi_pkg::result_t load_res [sdi_pkg::RES_SLOTS],
  input  logic [1:0]       load_cnt,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_stall,
  output sdi_pkg::result_t out_res
);
  import sdi_pkg::*;

  result_t    ent_r [RES_SLOTS];
  logic [1:0] cnt_r;
  logic [1:0] idx_r;
  logic       fire;
  logic       drain_last;

  assign out_valid  = (cnt_r != 2'd0);
  assign out_res    = ent_r[idx_r];
  assign fire       = out_valid && !out_stall;
  assign drain_last = fire && (idx_r == cnt_r - 2'd1);
  assign can_load   = !out_valid || drain_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else if (load) begin
      cnt_r <= load_cnt;
      idx_r <= 2'd0;
    end else if (drain_last) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else if (fire) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < RES_SLOTS; i++) ent_r[i] <= load_res[i];
    end
  end

endmodule

// ===== rtl/core/sd_card_init_sequencer.sv =====
// ---------------------------------------------------------------------------
// sd_card_init_sequencer: SD-bus card identification sequencer
// Turns start requests and command / test-read outcomes into the next bus
// actions of the SD card initialization flow.
// ---------------------------------------------------------------------------
// An event transaction is captured in an input register, decoded once the
// result bank can take its results, and its up to three result transactions
// are loaded into a three-entry result bank that presents them one per cycle
// while out_stall is low, last flagged on the final one. With the bank free,
// an event passes the input register and then the result bank before its
// first result can be taken. Events with at most one result flow at one per
// cycle while out_stall is low, and the sustained rate is set by the result
// bank draining one entry a cycle. A new event is taken into the input
// register while results still wait on the output. Events that cause no
// result are absorbed once the result bank is free. Write the two limit
// registers only while the block is idle.
module sd_card_init_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  // event channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_operation,
  input  logic        in_status_ok,
  input  logic [31:0] in_response_word,
  input  logic [3:0]  in_group1_function,
  input  logic        in_data_ok,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_action,
  output logic [5:0]  out_cmd_index,
  output logic [31:0] out_cmd_argument,
  output logic        out_skip_crc_check,
  output logic        out_stop_clock_after,
  output logic        out_expect_response,
  output logic [6:0]  out_read_bytes,
  output logic [1:0]  out_timing_mode,
  output logic        out_success,
  output logic        out_high_capacity,
  output logic        out_last,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data
);
  import sdi_pkg::*;

  logic       in_vld_r;
  item_t      item_r;
  state_t     st_r;
  state_t     st_nxt;
  logic [3:0] probe_limit_r;
  logic [9:0] poll_limit_r;
  result_t    step_res [RES_SLOTS];
  logic [1:0] step_cnt;
  logic       bank_can_load;
  logic       load;
  result_t    out_res;

  // Decode the held event once the bank can take its results.
  assign load     = in_vld_r && bank_can_load;
  assign in_stall = in_vld_r && !bank_can_load;

  // Input register: capture a new transaction, drop the held one once decoded.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_vld_r <= 1'b1;
    end else if (load) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.operation       <= in_operation;
      item_r.status_ok       <= in_status_ok;
      item_r.response_word   <= in_response_word;
      item_r.group1_function <= in_group1_function;
      item_r.data_ok         <= in_data_ok;
    end
  end

  // Sequencer state: advance only when an event is decoded. All zero is the
  // idle phase with every counter and flag cleared.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (load) begin
      st_r <= st_nxt;
    end
  end

  // Limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_limit_r <= PROBE_LIMIT_RST;
      poll_limit_r  <= POLL_LIMIT_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_PROBE_LIMIT: probe_limit_r <= cfg_data[3:0];
        CFG_POLL_LIMIT:  poll_limit_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  sdi_step u_step (
    .st          (st_r),
    .item        (item_r),
    .probe_limit (probe_limit_r),
    .poll_limit  (poll_limit_r),
    .st_nxt      (st_nxt),
    .res         (step_res),
    .res_cnt     (step_cnt)
  );

  sdi_result_bank u_bank (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_res  (step_res),
    .load_cnt  (step_cnt),
    .can_load  (bank_can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_action           = out_res.action;
  assign out_cmd_index        = out_res.cmd_index;
  assign out_cmd_argument     = out_res.cmd_argument;
  assign out_skip_crc_check   = out_res.skip_crc_check;
  assign out_stop_clock_after = out_res.stop_clock_after;
  assign out_expect_response  = out_res.expect_response;
  assign out_read_bytes       = out_res.read_bytes;
  assign out_timing_mode      = out_res.timing_mode;
  assign out_success          = out_res.success;
  assign out_high_capacity    = out_res.high_capacity;
  assign out_last             = out_res.last;

endmodule
